/* rtl/oaht_pkg.sv */
package oaht_pkg;

   // Default build parameters
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_KEY_WIDTH   = 31;

   // Fixed field widths
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int SIZE_W     = 11;
   localparam int PMODE_W    = 2;
   localparam int PRIME_W    = 10;
   localparam int ST_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Operation codes
   localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] OP_ERASE  = 2'd1;
   localparam logic [MODE_W-1:0] OP_SEARCH = 2'd2;

   // Probe modes
   localparam logic [PMODE_W-1:0] PM_LINEAR = 2'd0;
   localparam logic [PMODE_W-1:0] PM_QUAD   = 2'd1;
   localparam logic [PMODE_W-1:0] PM_DOUBLE = 2'd2;

   // Slot states
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
   localparam logic [ST_W-1:0] ST_USED    = 2'd1;
   localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] RS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] RS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] RS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] RS_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] RS_NOTFOUND  = 3'd4;
   localparam logic [STATUS_W-1:0] RS_FOUND     = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PRIME = 2'd2;

   // Register reset values
   localparam logic [SIZE_W-1:0]  RST_TABLE_SIZE = 11'd1024;
   localparam logic [PMODE_W-1:0] RST_PROBE_MODE = PM_LINEAR;
   localparam logic [PRIME_W-1:0] RST_STEP_PRIME = 10'd1021;

endpackage

/* rtl/oaht_if.sv */
// Request channel: operation and key
interface oaht_req_if #(parameter int KEY_WIDTH = oaht_pkg::DEF_KEY_WIDTH);
   logic                        valid;
   logic                        ready;
   logic [oaht_pkg::MODE_W-1:0] mode;
   logic [KEY_WIDTH-1:0]        key;

   modport source (output valid, mode, key, input ready);
   modport sink   (input valid, mode, key, output ready);
endinterface

// Response channel: one result per operation
interface oaht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oaht_pkg::STATUS_W-1:0] status;
   logic [oaht_pkg::SLOT_W-1:0]   slot;
   logic [oaht_pkg::COUNT_W-1:0]  probe_count;
   logic [oaht_pkg::COUNT_W-1:0]  key_count;

   modport source (output valid, status, slot, probe_count, key_count, input ready);
   modport sink   (input valid, status, slot, probe_count, key_count, output ready);
endinterface

// Register write channel
interface oaht_csr_if;
   logic                            valid;
   logic                            ready;
   logic [oaht_pkg::CSR_IDX_W-1:0]  index;
   logic [oaht_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/oaht_ram.sv */
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/oaht_div.sv */
module oaht_div #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [DEN_W-1:0] rem
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;

   // Restoring remainder, one numerator bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= {1'b0, den_ff}) ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in  = num_ff << 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/open_addressing_hash_table.sv */
// Sequence: one key-mod-size division, preceded in double hashing mode by two more
// (key mod prime, then step mod size), then the probes and the hand-off of the result.
// One operation at a time; a full-table insert skips the divisions and the probes.
// The bit-serial divider is shared by all divisions; the table has a single read port.
// Reset: synchronous; afterwards the table is swept empty, one slot per cycle, with
// the request channel not ready (register writes still taken).
module open_addressing_hash_table #(
   parameter int TABLE_DEPTH = oaht_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = oaht_pkg::DEF_KEY_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   oaht_req_if.sink   req_ch,
   oaht_rsp_if.source rsp_ch,
   oaht_csr_if.sink   csr_ch
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W   = ADDR_W + 1;
   localparam int PRIME_W = oaht_pkg::PRIME_W;
   localparam int DEN_W   = (CNT_W > PRIME_W) ? CNT_W : PRIME_W;
   localparam int NUM_W   = (KEY_WIDTH > PRIME_W) ? KEY_WIDTH : PRIME_W;
   localparam int WORD_W  = KEY_WIDTH + oaht_pkg::ST_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_P,
      S_DIV_S,
      S_DIV_H,
      S_PROBE,
      S_DONE
   } state_type;

   // Configuration registers
   logic [oaht_pkg::SIZE_W-1:0]  ts_ff;
   logic [oaht_pkg::PMODE_W-1:0] pm_ff;
   logic [PRIME_W-1:0]           sp_ff;

   // Sequencer state and operation context
   state_type                      state_ff, state_in;
   logic [oaht_pkg::MODE_W-1:0]    op_ff, op_in;
   logic [KEY_WIDTH-1:0]           key_ff, key_in;
   logic [CNT_W-1:0]               size_ff, size_in;
   logic [ADDR_W-1:0]              home_ff, home_in;
   logic [ADDR_W-1:0]              p_ff, p_in;
   logic [ADDR_W-1:0]              d_ff, d_in;
   logic [ADDR_W-1:0]              step_ff, step_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [CNT_W-1:0]               stored_ff, stored_in;
   logic [oaht_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [ADDR_W-1:0]              clr_ff, clr_in;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [oaht_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [oaht_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [oaht_pkg::COUNT_W-1:0]   rsp_probe_ff, rsp_probe_in;
   logic [oaht_pkg::COUNT_W-1:0]   rsp_keys_ff, rsp_keys_in;

   // Derived configuration
   logic [CNT_W-1:0]   eff_size;
   logic [PRIME_W-1:0] prime_eff;
   logic [PRIME_W-1:0] step_raw;

   // Probe address arithmetic
   logic [ADDR_W-1:0] incr;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  size_ext;
   logic [ADDR_W-1:0] nxt;
   logic [SUM_W-1:0]  dsum, d1, d2;

   // Table access
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [WORD_W-1:0]          ram_wdata;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [WORD_W-1:0]          ram_rdata;
   logic [oaht_pkg::ST_W-1:0]  rd_state;
   logic [KEY_WIDTH-1:0]       rd_key;
   logic                       is_used;
   logic                       key_hit;
   logic                       wrap;

   // Divider control
   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [DEN_W-1:0] div_rem;

   logic req_acc;
   logic out_free;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= oaht_pkg::RST_TABLE_SIZE;
         pm_ff <= oaht_pkg::RST_PROBE_MODE;
         sp_ff <= oaht_pkg::RST_STEP_PRIME;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            oaht_pkg::CSR_TABLE_SIZE: ts_ff <= csr_ch.data[oaht_pkg::SIZE_W-1:0];
            oaht_pkg::CSR_PROBE_MODE: pm_ff <= csr_ch.data[oaht_pkg::PMODE_W-1:0];
            oaht_pkg::CSR_STEP_PRIME: sp_ff <= csr_ch.data[PRIME_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // Size clamped to 1..TABLE_DEPTH, prime zero taken as one
   always_comb begin
      if (ts_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (32'(ts_ff) > TABLE_DEPTH) begin
         eff_size = CNT_W'(TABLE_DEPTH);
      end else begin
         eff_size = CNT_W'(ts_ff);
      end
   end

   assign prime_eff = (sp_ff == '0) ? PRIME_W'(1) : sp_ff;
   assign step_raw  = prime_eff - PRIME_W'(div_rem);

   // Next probe: previous slot plus linear one, quadratic odd offset or double step
   always_comb begin
      case (pm_ff)
         oaht_pkg::PM_LINEAR: incr = ADDR_W'(1);
         oaht_pkg::PM_QUAD:   incr = d_ff;
         oaht_pkg::PM_DOUBLE: incr = step_ff;
         default:             incr = ADDR_W'(1);
      endcase
      size_ext = SUM_W'(size_ff);
      sum      = SUM_W'(p_ff) + SUM_W'(incr);
      nxt      = (sum >= size_ext) ? ADDR_W'(sum - size_ext) : ADDR_W'(sum);
      // Quadratic offset 2i-1 advances by two each probe
      dsum     = SUM_W'(d_ff) + SUM_W'(2);
      d1       = (dsum >= size_ext) ? (dsum - size_ext) : dsum;
      d2       = (d1 >= size_ext) ? (d1 - size_ext) : d1;
   end

   assign rd_state = ram_rdata[KEY_WIDTH +: oaht_pkg::ST_W];
   assign rd_key   = ram_rdata[KEY_WIDTH-1:0];
   assign is_used  = (rd_state == oaht_pkg::ST_USED);
   assign key_hit  = is_used && (rd_key == key_ff);
   assign wrap     = (nxt == home_ff);

   assign req_acc  = req_ch.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      home_in       = home_ff;
      p_in          = p_ff;
      d_in          = d_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      stored_in     = stored_ff;
      status_in     = status_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probe_in  = rsp_probe_ff;
      rsp_keys_in   = rsp_keys_ff;
      ram_we        = 1'b0;
      ram_waddr     = p_ff;
      ram_wdata     = {oaht_pkg::ST_USED, key_ff};
      ram_raddr     = p_ff;
      div_start     = 1'b0;
      div_num       = NUM_W'(key_ff);
      div_den       = DEN_W'(size_ff);

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {oaht_pkg::ST_EMPTY, {KEY_WIDTH{1'b0}}};
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_acc) begin
               key_in  = req_ch.key;
               size_in = eff_size;
               if (req_ch.mode == oaht_pkg::OP_INSERT || req_ch.mode == oaht_pkg::OP_ERASE) begin
                  op_in = req_ch.mode;
               end else begin
                  op_in = oaht_pkg::OP_SEARCH;
               end
               if (req_ch.mode == oaht_pkg::OP_INSERT && stored_ff >= eff_size) begin
                  // Table already full: nothing probed
                  status_in = oaht_pkg::RS_FULL;
                  p_in      = '0;
                  cnt_in    = '0;
                  state_in  = S_DONE;
               end else if (pm_ff == oaht_pkg::PM_DOUBLE) begin
                  div_start = 1'b1;
                  div_num   = NUM_W'(req_ch.key);
                  div_den   = DEN_W'(prime_eff);
                  state_in  = S_DIV_P;
               end else begin
                  div_start = 1'b1;
                  div_num   = NUM_W'(req_ch.key);
                  div_den   = DEN_W'(eff_size);
                  state_in  = S_DIV_H;
               end
            end
         end

         S_DIV_P: begin
            // step = prime - key mod prime, then reduced mod size
            if (div_done) begin
               div_start = 1'b1;
               div_num   = NUM_W'(step_raw);
               div_den   = DEN_W'(size_ff);
               state_in  = S_DIV_S;
            end
         end

         S_DIV_S: begin
            if (div_done) begin
               step_in   = ADDR_W'(div_rem);
               div_start = 1'b1;
               div_num   = NUM_W'(key_ff);
               div_den   = DEN_W'(size_ff);
               state_in  = S_DIV_H;
            end
         end

         S_DIV_H: begin
            if (div_done) begin
               home_in   = ADDR_W'(div_rem);
               p_in      = ADDR_W'(div_rem);
               ram_raddr = ADDR_W'(div_rem);
               d_in      = (size_ff == CNT_W'(1)) ? '0 : ADDR_W'(1);
               cnt_in    = '0;
               state_in  = S_PROBE;
            end
         end

         S_PROBE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (op_ff == oaht_pkg::OP_INSERT) begin
               if (!is_used) begin
                  ram_we    = 1'b1;
                  stored_in = stored_ff + CNT_W'(1);
                  status_in = oaht_pkg::RS_INSERTED;
                  state_in  = S_DONE;
               end else if (key_hit) begin
                  status_in = oaht_pkg::RS_DUPLICATE;
                  state_in  = S_DONE;
               end else if (wrap) begin
                  status_in = oaht_pkg::RS_FULL;
                  state_in  = S_DONE;
               end else begin
                  p_in      = nxt;
                  d_in      = ADDR_W'(d2);
                  ram_raddr = nxt;
               end
            end else begin
               if (rd_state == oaht_pkg::ST_EMPTY) begin
                  status_in = oaht_pkg::RS_NOTFOUND;
                  state_in  = S_DONE;
               end else if (key_hit) begin
                  if (op_ff == oaht_pkg::OP_ERASE) begin
                     // Leave a tombstone
                     ram_we    = 1'b1;
                     ram_wdata = {oaht_pkg::ST_DELETED, key_ff};
                     if (stored_ff != '0) begin
                        stored_in = stored_ff - CNT_W'(1);
                     end
                     status_in = oaht_pkg::RS_REMOVED;
                  end else begin
                     status_in = oaht_pkg::RS_FOUND;
                  end
                  state_in = S_DONE;
               end else if (wrap) begin
                  status_in = oaht_pkg::RS_NOTFOUND;
                  state_in  = S_DONE;
               end else begin
                  p_in      = nxt;
                  d_in      = ADDR_W'(d2);
                  ram_raddr = nxt;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = oaht_pkg::SLOT_W'(p_ff);
               rsp_probe_in  = oaht_pkg::COUNT_W'(cnt_ff);
               rsp_keys_in   = oaht_pkg::COUNT_W'(stored_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      home_ff       <= home_in;
      p_ff          <= p_in;
      d_ff          <= d_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probe_ff  <= rsp_probe_in;
      rsp_keys_ff   <= rsp_keys_in;
   end

   // Shared remainder unit
   oaht_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .rem   (div_rem)
   );

   // Slot table: state and key per slot
   oaht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.probe_count = rsp_probe_ff;
   assign rsp_ch.key_count   = rsp_keys_ff;

endmodule

/* rtl/oaht_checker.sv */
module oaht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [oaht_pkg::STATUS_W-1:0] rsp_status,
   input logic [oaht_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [oaht_pkg::COUNT_W-1:0]  rsp_probe_count,
   input logic [oaht_pkg::COUNT_W-1:0]  rsp_key_count
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_probe_count) && $stable(rsp_key_count))
      else $error("response changed while stalled");

   // One operation at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Every answer except full probed at least one slot
   a_probed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != oaht_pkg::RS_FULL |-> rsp_probe_count != '0)
      else $error("result without probe");

   // Full without probing reports slot zero
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == oaht_pkg::RS_FULL && rsp_probe_count == '0
         |-> rsp_slot == '0)
      else $error("early full with nonzero slot");

   // A new response never appears right after a request transaction
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_slot        (rsp_ch.slot),
   .rsp_probe_count (rsp_ch.probe_count),
   .rsp_key_count   (rsp_ch.key_count)
);

/* tb/open_addressing_hash_table_test.sv */
`timescale 1ns / 1ps

module open_addressing_hash_table_test;
   import oaht_pkg::*;

   localparam int KEY_W          = DEF_KEY_WIDTH;
   localparam int DEPTH          = DEF_TABLE_DEPTH;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int HOLD_AT_RESULT = 400;
   localparam int HOLD_CYCLES    = 600;

   // Encodings the package leaves unnamed; the block folds them onto others
   localparam logic [MODE_W-1:0]  OP_SPARE  = 2'd3;
   localparam logic [PMODE_W-1:0] PM_SPARE  = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  probe_count;
      logic [COUNT_W-1:0]  key_count;
   } hash_result_type;

   // Mirror of the key set plus the queue of results still owed by the block
   class hash_set_scoreboard;
      logic [KEY_W-1:0]   key_at [DEPTH];
      logic [ST_W-1:0]    state_at [DEPTH];
      int unsigned        occupancy;
      logic [SIZE_W-1:0]  size_reg;
      logic [PMODE_W-1:0] probe_reg;
      logic [PRIME_W-1:0] prime_reg;
      hash_result_type    pending_results[$];
      int unsigned        failures;
      int unsigned        results_checked;
      int unsigned        status_seen[8];

      function new();
         foreach (state_at[i]) state_at[i] = ST_EMPTY;
         occupancy = 0;
         size_reg = RST_TABLE_SIZE;
         probe_reg = RST_PROBE_MODE;
         prime_reg = RST_STEP_PRIME;
         failures = 0;
         results_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_TABLE_SIZE: size_reg = value[SIZE_W-1:0];
            CSR_PROBE_MODE: probe_reg = value[PMODE_W-1:0];
            CSR_STEP_PRIME: prime_reg = value[PRIME_W-1:0];
            default: ;
         endcase
      endfunction

      function hash_result_type pack_result(logic [STATUS_W-1:0] st, longint unsigned pos,
                                            longint unsigned probes);
         hash_result_type r;
         r.status = st;
         r.slot = SLOT_W'(pos);
         r.probe_count = COUNT_W'(probes);
         r.key_count = COUNT_W'(occupancy);
         return r;
      endfunction

      function longint unsigned next_slot(longint unsigned pos, longint unsigned home,
                                          longint unsigned iter, longint unsigned stride,
                                          longint unsigned span);
         if (probe_reg == PM_QUAD) return (home + iter * iter) % span;
         if (probe_reg == PM_DOUBLE) return (home + iter * stride) % span;
         return (pos + 1) % span;
      endfunction

      // Walk the probe sequence and apply the operation to the mirror
      function hash_result_type resolve_operation(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key);
         longint unsigned span, prime, home, stride, pos, iter, probes, nxt;
         span = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
         prime = (prime_reg == 0) ? 1 : prime_reg;
         home = key % span;
         stride = prime - key % prime;
         pos = home;
         iter = 0;
         probes = 0;
         if (op == OP_INSERT) begin
            if (occupancy >= span) return pack_result(RS_FULL, 0, 0);
            forever begin
               probes++;
               if (state_at[pos] != ST_USED) begin
                  state_at[pos] = ST_USED;
                  key_at[pos] = key;
                  occupancy++;
                  return pack_result(RS_INSERTED, pos, probes);
               end
               if (key_at[pos] == key) return pack_result(RS_DUPLICATE, pos, probes);
               iter++;
               nxt = next_slot(pos, home, iter, stride, span);
               // probe sequence closed without a free slot
               if (nxt == home) return pack_result(RS_FULL, pos, probes);
               pos = nxt;
            end
         end
         // erase, search and the spare mode (acts as search)
         forever begin
            probes++;
            if (state_at[pos] == ST_EMPTY) break;
            if (state_at[pos] == ST_USED && key_at[pos] == key) begin
               if (op == OP_ERASE) begin
                  state_at[pos] = ST_DELETED;
                  if (occupancy != 0) occupancy--;
                  return pack_result(RS_REMOVED, pos, probes);
               end
               return pack_result(RS_FOUND, pos, probes);
            end
            iter++;
            nxt = next_slot(pos, home, iter, stride, span);
            if (nxt == home) break;
            pos = nxt;
         end
         return pack_result(RS_NOTFOUND, pos, probes);
      endfunction

      function void note_operation(logic [MODE_W-1:0] op, logic [KEY_W-1:0] key);
         pending_results = {pending_results, resolve_operation(op, key)};
      endfunction

      function void report_field(string field, int unsigned want, int unsigned got);
         failures++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_result(hash_result_type got);
         hash_result_type want;
         results_checked++;
         status_seen[got.status]++;
         if (pending_results.size() == 0) begin
            failures++;
            $error("unexpected result: status %0d slot %0d", got.status, got.slot);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status) report_field("status", want.status, got.status);
         if (got.slot !== want.slot) report_field("slot", want.slot, got.slot);
         if (got.probe_count !== want.probe_count)
            report_field("probe_count", want.probe_count, got.probe_count);
         if (got.key_count !== want.key_count)
            report_field("key_count", want.key_count, got.key_count);
      endfunction
   endclass

   logic clock;
   logic reset;

   oaht_req_if #(.KEY_WIDTH(KEY_W)) req_bus ();
   oaht_rsp_if rsp_bus ();
   oaht_csr_if csr_bus ();

   open_addressing_hash_table #(
      .TABLE_DEPTH(DEPTH),
      .KEY_WIDTH(KEY_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   hash_set_scoreboard sb = new();
   logic [KEY_W-1:0]   live_keys[$];
   bit                 calm = 1'b0;
   int unsigned        settings_written = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, one long hold-off, checks every transaction
   initial begin : response_side
      int unsigned     stall_left;
      int unsigned     hold_left;
      bit              held_once;
      hash_result_type got;
      stall_left = 0;
      hold_left = 0;
      held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.slot = rsp_bus.slot;
            got.probe_count = rsp_bus.probe_count;
            got.key_count = rsp_bus.key_count;
            sb.check_result(got);
            if (!held_once && sb.results_checked == HOLD_AT_RESULT) begin
               held_once = 1'b1;
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: cycles without any transaction on any channel
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("open_addressing_hash_table_test: FAIL");
            $finish;
         end
      end
   end

   task automatic send_operation(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= op;
      req_bus.key <= key;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_operation(op, key);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.apply_register(idx, value);
   endtask

   task automatic configure(input int unsigned size_val, input logic [PMODE_W-1:0] pmode_val,
                            input int unsigned prime_val);
      write_register(CSR_TABLE_SIZE, CSR_DATA_W'(size_val));
      write_register(CSR_PROBE_MODE, CSR_DATA_W'(pmode_val));
      write_register(CSR_STEP_PRIME, CSR_DATA_W'(prime_val));
      csr_bus.valid <= 1'b0;
      settings_written++;
   endtask

   // Erase every key this phase inserted so the next setting starts near empty
   task automatic erase_live_keys();
      foreach (live_keys[i]) send_operation(OP_ERASE, live_keys[i]);
      live_keys.delete();
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Collisions, tombstones, duplicates, a full table and every operation code
   task automatic run_directed();
      configure(8, PM_LINEAR, 7);
      send_operation(OP_INSERT, 0);
      send_operation(OP_INSERT, 8);
      send_operation(OP_INSERT, 16);
      send_operation(OP_INSERT, 8);
      send_operation(OP_SEARCH, 16);
      send_operation(OP_ERASE, 8);
      send_operation(OP_SEARCH, 16);
      send_operation(OP_INSERT, 24);
      send_operation(OP_SPARE, 24);
      send_operation(OP_ERASE, 99);
      send_operation(OP_INSERT, '1);
      send_operation(OP_INSERT, 3);
      send_operation(OP_INSERT, 4);
      send_operation(OP_INSERT, 5);
      send_operation(OP_INSERT, 6);
      // table now holds eight keys in eight slots
      send_operation(OP_INSERT, 1);
      send_operation(OP_SEARCH, 1);
      live_keys = '{0, 16, 24, '1, 3, 4, 5, 6};
      erase_live_keys();
      wait_for_drain();
   endtask

   // Random traffic under one setting, mostly on colliding and known keys
   task automatic run_phase(input int unsigned size_val, input logic [PMODE_W-1:0] pmode_val,
                            input int unsigned prime_val, input int unsigned items,
                            input bit sweep);
      longint unsigned  span;
      longint unsigned  raw;
      int unsigned      pick;
      int unsigned      n;
      logic [KEY_W-1:0] key;
      logic [MODE_W-1:0] op;
      bit               fresh;
      configure(size_val, pmode_val, prime_val);
      span = (size_val == 0) ? 1 : ((size_val > DEPTH) ? DEPTH : size_val);
      for (n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         fresh = 1'b1;
         if (pick < 45 && live_keys.size() != 0) begin
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            fresh = 1'b0;
         end else if (pick < 85) begin
            // few home slots, many keys: long probe chains
            raw = $urandom_range(0, 32'h1F_FFFF);
            raw = raw * span + $urandom_range(0, ((span < 6) ? span : 6) - 1);
            key = KEY_W'(raw);
         end else if (pick < 97) begin
            key = KEY_W'($urandom);
         end else begin
            key = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) op = OP_INSERT;
         else if (pick < 70) op = OP_SEARCH;
         else if (pick < 93) op = OP_ERASE;
         else op = OP_SPARE;
         send_operation(op, key);
         if (fresh && op == OP_INSERT) live_keys = {live_keys, key};
      end
      if (sweep) erase_live_keys();
      wait_for_drain();
   endtask

   initial begin : main_sequence
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= OP_INSERT;
      req_bus.key <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_TABLE_SIZE;
      csr_bus.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // size zero acts as one slot; probe mode three and prime zero fold over
      run_phase(0, PM_SPARE, 0, 60, 1'b1);
      run_phase(4, PM_QUAD, 3, 130, 1'b1);
      run_phase(7, PM_DOUBLE, 5, 150, 1'b1);
      run_phase(5, PM_QUAD, 1023, 130, 1'b1);
      run_phase(32, PM_SPARE, 31, 150, 1'b1);
      run_phase(37, PM_DOUBLE, 0, 130, 1'b1);
      // keys stay behind when the table shrinks from 16 to 13 slots
      run_phase(16, PM_QUAD, 13, 150, 1'b0);
      run_phase(13, PM_DOUBLE, 11, 150, 1'b1);
      // size above the depth saturates; bit 10 of the prime data is dropped
      run_phase(2047, PM_DOUBLE, 2047, 130, 1'b1);
      run_phase(64, PM_LINEAR, 61, 130, 1'b1);
      calm = 1'b1;
      run_phase(1024, PM_LINEAR, 1021, 230, 1'b0);

      req_bus.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("ran %0d operations over %0d register settings, %0d mismatches",
               sb.results_checked, settings_written, sb.failures);
      $display("inserted %0d, duplicate %0d, full %0d, removed %0d, not found %0d, found %0d",
               sb.status_seen[RS_INSERTED], sb.status_seen[RS_DUPLICATE],
               sb.status_seen[RS_FULL], sb.status_seen[RS_REMOVED],
               sb.status_seen[RS_NOTFOUND], sb.status_seen[RS_FOUND]);
      if (sb.failures == 0 && sb.pending_results.size() == 0)
         $display("open_addressing_hash_table_test: PASS");
      else
         $display("open_addressing_hash_table_test: FAIL");
      $finish;
   end

endmodule
